FILE: rtl/tpa_pkg.sv
// Package: shared types, constants and codes for the timestamp pair associator.
`timescale 1ns / 1ps
`default_nettype none
package tpa_pkg;

    localparam int unsigned QueueDepth = 16;
    localparam int unsigned IdxW       = $clog2(QueueDepth);
    localparam int unsigned CntW       = $clog2(QueueDepth + 1);
    localparam int unsigned StampW     = 63;
    localparam int unsigned HandleW    = 16;
    localparam int unsigned CfgW       = 63;
    localparam int unsigned QsW        = 5;

    localparam logic [1:0] CMD_PUSH_IMAGE = 2'd0;
    localparam logic [1:0] CMD_PUSH_DEPTH = 2'd1;
    localparam logic [1:0] CMD_POP        = 2'd2;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    localparam logic [1:0] ST_PUSHED  = 2'd0;
    localparam logic [1:0] ST_PAIR    = 2'd1;
    localparam logic [1:0] ST_NO_PAIR = 2'd2;

    localparam logic [0:0] REG_MAX_DIFF   = 1'd0;
    localparam logic [0:0] REG_QUEUE_SIZE = 1'd1;

    localparam logic [StampW-1:0] MaxDiffReset   = 63'd20000000;
    localparam logic [QsW-1:0]    QueueSizeReset = 5'd16;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [StampW-1:0]  stamp_ns;
        logic [HandleW-1:0] handle;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [StampW-1:0]  pair_diff;
        logic [StampW-1:0]  depth_time;
        logic [StampW-1:0]  image_time;
        logic [HandleW-1:0] depth_handle;
        logic [HandleW-1:0] image_handle;
        logic [4:0]         image_count;
        logic [4:0]         depth_count;
    } out_item_t;

    // Shared comparator operation request and result.
    typedef struct packed {
        logic [StampW-1:0] a;
        logic [StampW-1:0] b;
    } cmp_req_t;

    typedef struct packed {
        logic [StampW-1:0] diff;
        logic              a_lt_b;
        logic              a_eq_b;
    } cmp_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/tpa_cmp.sv
// Shared subtract and compare unit: absolute difference and ordering of two stamps.
`timescale 1ns / 1ps
`default_nettype none
module tpa_cmp (
    input  wire tpa_pkg::cmp_req_t req,
    output tpa_pkg::cmp_rsp_t      rsp
);
    logic [tpa_pkg::StampW:0] sub;

    always_comb begin
        sub        = {1'b0, req.a} - {1'b0, req.b};
        rsp.a_lt_b = sub[tpa_pkg::StampW];
        rsp.a_eq_b = (req.a == req.b);
        rsp.diff   = sub[tpa_pkg::StampW] ? (req.b - req.a) : sub[tpa_pkg::StampW-1:0];
    end
endmodule
`default_nettype wire

FILE: rtl/timestamp_pair_associator_unit.sv
// Top level: tables, sequencer and handshakes of the timestamp pair associator.
//
//  channel | ports                     | direction | handshake
//  input   | s_valid s_ready s_data    | in        | valid/ready beat
//  result  | m_valid m_ready m_data    | out       | valid/ready beat
//  config  | cfg_we cfg_index cfg_data | in        | write enable only
//
// Push: evicts the oldest entry on a full table, seeks an equal stamp and a free slot,
//   stores the item (only its handle on an equal stamp) and raises the result beat.
// Pop: each greedy round scans all N*N pairs, breaking ties on depth then image stamp,
//   then books the winner; up to N+1 rounds, then entries up to the pair are dropped.
// Reset clears valid bits, counts and control registers; no clearing pass.
// Not ready from acceptance until the result beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module timestamp_pair_associator_unit (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  tpa_pkg::in_item_t          s_data,
    output logic                             m_valid,
    input  wire                              m_ready,
    output tpa_pkg::out_item_t               m_data,
    input  wire                              cfg_we,
    input  wire  [0:0]                       cfg_index,
    input  wire  [tpa_pkg::CfgW-1:0]         cfg_data
);
    localparam int unsigned N  = tpa_pkg::QueueDepth;
    localparam int unsigned IW = tpa_pkg::IdxW;
    localparam int unsigned SW = tpa_pkg::StampW;
    localparam int unsigned HW = tpa_pkg::HandleW;

    typedef enum logic [3:0] {
        S_IDLE, S_OLD, S_EQ, S_INS, S_PD, S_PI, S_PWORK, S_PEND, S_DROP, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        W_CHK, W_DD, W_DI
    } work_t;

    state_t state_reg;
    work_t  work_reg;

    logic [SW-1:0] max_diff_reg;
    logic [4:0]    queue_size_reg;

    logic [SW-1:0] d_st_reg [N];
    logic [HW-1:0] d_hd_reg [N];
    logic [SW-1:0] i_st_reg [N];
    logic [HW-1:0] i_hd_reg [N];
    logic [N-1:0]  d_v_reg, i_v_reg, d_tk_reg, i_tk_reg;

    tpa_pkg::in_item_t  item_reg;
    tpa_pkg::out_item_t out_reg;
    logic               out_v_reg;

    logic [IW-1:0] d_idx_reg, i_idx_reg, k_reg;
    logic [IW-1:0] best_d_reg, best_i_reg;
    logic [SW-1:0] best_diff_reg;
    logic          best_ok_reg;
    logic [IW-1:0] first_d_reg, first_i_reg;
    logic [SW-1:0] first_diff_reg;
    logic          first_ok_reg;
    logic [IW-1:0] old_reg;
    logic          old_ok_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          free_ok_reg;
    logic [IW-1:0] free_idx_reg;

    logic          is_depth;
    logic [N-1:0]  tv;
    logic [SW-1:0] tst_k;
    logic [tpa_pkg::CntW-1:0] d_cnt, i_cnt;
    logic [tpa_pkg::CntW-1:0] eff;

    tpa_pkg::cmp_req_t req;
    tpa_pkg::cmp_rsp_t rsp;

    tpa_cmp u_cmp (.req(req), .rsp(rsp));

    always_comb begin
        d_cnt = '0;
        i_cnt = '0;
        for (int k = 0; k < N; k++) begin
            d_cnt = d_cnt + tpa_pkg::CntW'(d_v_reg[k]);
            i_cnt = i_cnt + tpa_pkg::CntW'(i_v_reg[k]);
        end
    end

    always_comb begin
        if (queue_size_reg == 5'd0) begin
            eff = tpa_pkg::CntW'(1);
        end else if (32'(queue_size_reg) > N) begin
            eff = tpa_pkg::CntW'(N);
        end else begin
            eff = tpa_pkg::CntW'(queue_size_reg);
        end
    end

    assign is_depth = (item_reg.cmd == tpa_pkg::CMD_PUSH_DEPTH);
    assign tv       = is_depth ? d_v_reg : i_v_reg;
    assign tst_k    = is_depth ? d_st_reg[k_reg] : i_st_reg[k_reg];

    // One comparator, operands chosen by phase.
    always_comb begin
        req.a = tst_k;
        req.b = item_reg.stamp_ns;
        unique case (state_reg)
            S_OLD: begin
                req.a = tst_k;
                req.b = is_depth ? d_st_reg[old_reg] : i_st_reg[old_reg];
            end
            S_PWORK: begin
                unique case (work_reg)
                    W_CHK: begin
                        req.a = d_st_reg[d_idx_reg];
                        req.b = i_st_reg[i_idx_reg];
                    end
                    W_DD: begin
                        req.a = d_st_reg[d_idx_reg];
                        req.b = d_st_reg[best_d_reg];
                    end
                    W_DI: begin
                        req.a = i_st_reg[i_idx_reg];
                        req.b = i_st_reg[best_i_reg];
                    end
                    default: begin
                        req.a = tst_k;
                    end
                endcase
            end
            S_PEND: begin
                req.a = d_st_reg[best_d_reg];
                req.b = d_st_reg[first_d_reg];
            end
            S_DROP: begin
                req.a = d_st_reg[k_reg];
                req.b = out_reg.depth_time;
            end
            S_DONE: begin
                req.a = i_st_reg[k_reg];
                req.b = out_reg.image_time;
            end
            default: begin
                req.a = tst_k;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    logic pair_live;
    assign pair_live = d_v_reg[d_idx_reg] && !d_tk_reg[d_idx_reg]
                    && i_v_reg[i_idx_reg] && !i_tk_reg[i_idx_reg];

    // Counts are sampled when the beat is raised.
    logic [4:0] fin_i, fin_d;
    always_comb begin
        fin_i = 5'(i_cnt);
        fin_d = 5'(d_cnt);
        if (state_reg == S_DONE && out_reg.status == tpa_pkg::ST_PAIR
                && i_v_reg[k_reg] && (rsp.a_lt_b || rsp.a_eq_b)) begin
            fin_i = 5'(i_cnt) - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            work_reg       <= W_CHK;
            max_diff_reg   <= tpa_pkg::MaxDiffReset;
            queue_size_reg <= tpa_pkg::QueueSizeReset;
            d_v_reg        <= '0;
            i_v_reg        <= '0;
            d_tk_reg       <= '0;
            i_tk_reg       <= '0;
            out_v_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    tpa_pkg::REG_MAX_DIFF:   max_diff_reg   <= cfg_data;
                    tpa_pkg::REG_QUEUE_SIZE: queue_size_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (out_v_reg && m_ready) begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        item_reg      <= s_data;
                        k_reg         <= '0;
                        old_ok_reg    <= 1'b0;
                        hit_reg       <= 1'b0;
                        free_ok_reg   <= 1'b0;
                        out_reg       <= '0;
                        d_idx_reg     <= '0;
                        i_idx_reg     <= '0;
                        best_ok_reg   <= 1'b0;
                        first_ok_reg  <= 1'b0;
                        work_reg      <= W_CHK;
                        unique case (s_data.cmd)
                            tpa_pkg::CMD_PUSH_IMAGE: begin
                                state_reg <= (i_cnt >= eff) ? S_OLD : S_EQ;
                            end
                            tpa_pkg::CMD_PUSH_DEPTH: begin
                                state_reg <= (d_cnt >= eff) ? S_OLD : S_EQ;
                            end
                            tpa_pkg::CMD_POP: state_reg <= S_PWORK;
                            default:          state_reg <= S_INS;
                        endcase
                    end
                end
                // Find oldest valid entry.
                S_OLD: begin
                    if (tv[k_reg] && (!old_ok_reg || rsp.a_lt_b)) begin
                        old_reg    <= k_reg;
                        old_ok_reg <= 1'b1;
                    end
                    k_reg <= k_reg + 1'b1;
                    if (32'(k_reg) == N - 1) begin
                        state_reg <= S_PD;
                    end
                end
                // Evict oldest.
                S_PD: begin
                    if (old_ok_reg) begin
                        if (is_depth) d_v_reg[old_reg] <= 1'b0;
                        else          i_v_reg[old_reg] <= 1'b0;
                    end
                    k_reg     <= '0;
                    state_reg <= S_EQ;
                end
                // Look for equal stamp and first free slot.
                S_EQ: begin
                    if (tv[k_reg] && rsp.a_eq_b && !hit_reg) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= k_reg;
                    end
                    if (!tv[k_reg] && !free_ok_reg) begin
                        free_ok_reg  <= 1'b1;
                        free_idx_reg <= k_reg;
                    end
                    k_reg <= k_reg + 1'b1;
                    if (32'(k_reg) == N - 1) begin
                        state_reg <= S_PI;
                    end
                end
                S_PI: begin
                    if (hit_reg) begin
                        if (is_depth) d_hd_reg[hit_idx_reg] <= item_reg.handle;
                        else          i_hd_reg[hit_idx_reg] <= item_reg.handle;
                    end else if (free_ok_reg) begin
                        if (is_depth) begin
                            d_v_reg[free_idx_reg]  <= 1'b1;
                            d_st_reg[free_idx_reg] <= item_reg.stamp_ns;
                            d_hd_reg[free_idx_reg] <= item_reg.handle;
                        end else begin
                            i_v_reg[free_idx_reg]  <= 1'b1;
                            i_st_reg[free_idx_reg] <= item_reg.stamp_ns;
                            i_hd_reg[free_idx_reg] <= item_reg.handle;
                        end
                    end
                    state_reg <= S_INS;
                end
                S_INS: begin
                    state_reg <= S_DONE;
                    k_reg     <= '0;
                end
                // Greedy round: scan all pairs, breaking a tied difference on depth then image stamp.
                S_PWORK: begin
                    unique case (work_reg)
                        W_CHK: begin
                            if (pair_live && rsp.diff < max_diff_reg) begin
                                if (!best_ok_reg || rsp.diff < best_diff_reg) begin
                                    best_ok_reg   <= 1'b1;
                                    best_d_reg    <= d_idx_reg;
                                    best_i_reg    <= i_idx_reg;
                                    best_diff_reg <= rsp.diff;
                                    work_reg      <= W_CHK;
                                end else if (rsp.diff == best_diff_reg) begin
                                    work_reg <= W_DD;
                                end
                            end
                        end
                        W_DD: begin
                            if (rsp.a_lt_b) begin
                                best_d_reg <= d_idx_reg;
                                best_i_reg <= i_idx_reg;
                                work_reg   <= W_CHK;
                            end else if (rsp.a_eq_b) begin
                                work_reg <= W_DI;
                            end else begin
                                work_reg <= W_CHK;
                            end
                        end
                        W_DI: begin
                            if (rsp.a_lt_b) begin
                                best_d_reg <= d_idx_reg;
                                best_i_reg <= i_idx_reg;
                            end
                            work_reg <= W_CHK;
                        end
                        default: work_reg <= W_CHK;
                    endcase
                    // Advance pair index when no tie pass follows.
                    if ((work_reg == W_CHK && !(pair_live && rsp.diff < max_diff_reg
                            && best_ok_reg && rsp.diff == best_diff_reg))
                        || (work_reg == W_DD && !rsp.a_eq_b) || work_reg == W_DI) begin
                        i_idx_reg <= i_idx_reg + 1'b1;
                        if (32'(i_idx_reg) == N - 1) begin
                            d_idx_reg <= d_idx_reg + 1'b1;
                            if (32'(d_idx_reg) == N - 1) begin
                                state_reg <= S_PEND;
                            end
                        end
                    end
                end
                S_PEND: begin
                    if (best_ok_reg) begin
                        d_tk_reg[best_d_reg] <= 1'b1;
                        i_tk_reg[best_i_reg] <= 1'b1;
                        if (!first_ok_reg || rsp.a_lt_b) begin
                            first_ok_reg   <= 1'b1;
                            first_d_reg    <= best_d_reg;
                            first_i_reg    <= best_i_reg;
                            first_diff_reg <= best_diff_reg;
                        end
                        best_ok_reg <= 1'b0;
                        d_idx_reg   <= '0;
                        i_idx_reg   <= '0;
                        work_reg    <= W_CHK;
                        state_reg   <= S_PWORK;
                    end else begin
                        d_tk_reg <= '0;
                        i_tk_reg <= '0;
                        k_reg    <= '0;
                        if (first_ok_reg) begin
                            out_reg.status       <= tpa_pkg::ST_PAIR;
                            out_reg.pair_diff    <= first_diff_reg;
                            out_reg.depth_time   <= d_st_reg[first_d_reg];
                            out_reg.image_time   <= i_st_reg[first_i_reg];
                            out_reg.depth_handle <= d_hd_reg[first_d_reg];
                            out_reg.image_handle <= i_hd_reg[first_i_reg];
                            state_reg            <= S_DROP;
                        end else begin
                            out_reg.status <= tpa_pkg::ST_NO_PAIR;
                            state_reg      <= S_INS;
                        end
                    end
                end
                // Drop depth entries at or before the paired stamp.
                S_DROP: begin
                    if (d_v_reg[k_reg] && (rsp.a_lt_b || rsp.a_eq_b)) begin
                        d_v_reg[k_reg] <= 1'b0;
                    end
                    k_reg <= k_reg + 1'b1;
                    if (32'(k_reg) == N - 1) begin
                        state_reg <= S_DONE;
                    end
                end
                // Drop image entries on a pair, then emit the result beat.
                S_DONE: begin
                    if (out_reg.status == tpa_pkg::ST_PAIR) begin
                        if (i_v_reg[k_reg] && (rsp.a_lt_b || rsp.a_eq_b)) begin
                            i_v_reg[k_reg] <= 1'b0;
                        end
                        k_reg <= k_reg + 1'b1;
                    end
                    if (out_reg.status != tpa_pkg::ST_PAIR || 32'(k_reg) == N - 1) begin
                        state_reg           <= S_IDLE;
                        out_v_reg           <= 1'b1;
                        out_reg.image_count <= fin_i;
                        out_reg.depth_count <= fin_d;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("accepted twice");
    a_taken_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> (d_tk_reg == '0 && i_tk_reg == '0))
        else $error("taken bits left set");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.depth_count <= 5'(N) && m_data.image_count <= 5'(N)))
        else $error("count out of range");
`endif
endmodule
`default_nettype wire
